/* rtl/nvme_prp_pkg.sv */
package nvme_prp_pkg;

    localparam int ADDR_W = 64;
    localparam int BLK_W = 16;
    localparam int LEN_W = 29;
    localparam int PTR_W = 17;

    localparam int PAGE_SHIFT_DEF = 12;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic FUNC_CMD = 1'b0;
    localparam logic FUNC_ENTRY = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE = 2'd1;
    localparam logic [1:0] PUSH_TWO = 2'd2;

    typedef struct packed {
        logic              func;
        logic              to_host;
        logic [ADDR_W-1:0] first_pointer;
        logic [ADDR_W-1:0] second_pointer;
        logic [BLK_W-1:0]  block_count_minus_one;
        logic [ADDR_W-1:0] list_entry;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic              to_host_out;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  byte_length;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

endpackage

/* rtl/nvme_prp_in_if.sv */
interface nvme_prp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic                              to_host;
    logic [nvme_prp_pkg::ADDR_W-1:0]   first_pointer;
    logic [nvme_prp_pkg::ADDR_W-1:0]   second_pointer;
    logic [nvme_prp_pkg::BLK_W-1:0]    block_count_minus_one;
    logic [nvme_prp_pkg::ADDR_W-1:0]   list_entry;

    modport source
    (
        output valid, func, to_host, first_pointer, second_pointer,
               block_count_minus_one, list_entry,
        input  ready
    );

    modport sink
    (
        input  valid, func, to_host, first_pointer, second_pointer,
               block_count_minus_one, list_entry,
        output ready
    );
endinterface

/* rtl/nvme_prp_out_if.sv */
interface nvme_prp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic                              to_host_out;
    logic [nvme_prp_pkg::ADDR_W-1:0]   address;
    logic [nvme_prp_pkg::LEN_W-1:0]    byte_length;
    logic                              last;

    modport source
    (
        output valid, kind, to_host_out, address, byte_length, last,
        input  ready
    );

    modport sink
    (
        input  valid, kind, to_host_out, address, byte_length, last,
        output ready
    );
endinterface

/* rtl/nvme_prp_walk.sv */
module nvme_prp_walk
#(
    parameter int PAGE_SHIFT = nvme_prp_pkg::PAGE_SHIFT_DEF,
    parameter int BLOCK_BYTES = nvme_prp_pkg::BLOCK_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  nvme_prp_pkg::in_item_t in_item,
    input  logic                   room,
    output nvme_prp_pkg::push_t    push
);

    localparam int LEN_W = nvme_prp_pkg::LEN_W;
    localparam int PTR_W = nvme_prp_pkg::PTR_W;
    localparam int ADDR_W = nvme_prp_pkg::ADDR_W;
    localparam int SPAN_W = LEN_W + 1;
    localparam int SLOT_W = PAGE_SHIFT - 3;
    localparam int SEG_W = PAGE_SHIFT - 2;
    localparam logic [LEN_W-1:0] PAGE_BYTES = LEN_W'(1) << PAGE_SHIFT;
    localparam logic [SPAN_W-1:0] PAGE_LOW_ONES = (SPAN_W'(1) << PAGE_SHIFT) - SPAN_W'(1);
    localparam logic [SEG_W-1:0] SLOTS = SEG_W'(1) << SLOT_W;
    localparam logic [ADDR_W-1:0] PAGE_ADDR_MASK = ~((ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1));
    localparam logic [ADDR_W-1:0] LIST_ADDR_MASK = ~ADDR_W'(3);

    logic                   stage_valid_reg;
    nvme_prp_pkg::in_item_t item_reg;
    logic                   advance;

    logic                   busy_reg, busy_next;
    logic                   dir_reg, dir_next;
    logic [LEN_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [PTR_W-1:0]       ptr_left_reg, ptr_left_next;
    logic [SEG_W-1:0]       seg_left_reg, seg_left_next;
    logic                   chain_reg, chain_next;

    logic [PTR_W:0]         nlb_p1;
    logic [LEN_W-1:0]       data_len;
    logic [PAGE_SHIFT-1:0]  start;
    logic [SPAN_W-1:0]      span;
    logic [SPAN_W-1:0]      pages;
    logic [LEN_W-1:0]       first_len;

    logic [ADDR_W-1:0]      seg_addr;
    logic [PTR_W-1:0]       seg_ptrs;
    logic [SLOT_W-1:0]      offset;
    logic [PTR_W:0]         slot_sum;
    logic [SEG_W-1:0]       free_slots;
    logic                   seg_chain;
    logic [SEG_W-1:0]       seg_count;
    logic [PTR_W-1:0]       seg_ptr_next;
    logic [SEG_W-1:0]       seg_data;
    nvme_prp_pkg::out_item_t fetch_item;

    logic [LEN_W-1:0]       entry_len;
    logic [SEG_W-1:0]       seg_dec;
    logic                   entry_last;

    assign advance = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || room;

    // command sizing
    always_comb
    begin
        nlb_p1 = (PTR_W + 1)'(item_reg.block_count_minus_one) + (PTR_W + 1)'(1);
        data_len = LEN_W'(32'(nlb_p1) * 32'(BLOCK_BYTES));
        start = item_reg.first_pointer[PAGE_SHIFT-1:0];
        span = SPAN_W'(start) + SPAN_W'(data_len) + PAGE_LOW_ONES;
        pages = span >> PAGE_SHIFT;
        first_len = PAGE_BYTES - LEN_W'(start);
    end

    // segment open, shared by the command and the chain pointer
    always_comb
    begin
        if (item_reg.func == nvme_prp_pkg::FUNC_ENTRY)
        begin
            seg_addr = item_reg.list_entry & LIST_ADDR_MASK;
            seg_ptrs = ptr_left_reg;
        end
        else
        begin
            seg_addr = item_reg.second_pointer & LIST_ADDR_MASK;
            seg_ptrs = PTR_W'(pages - SPAN_W'(1));
        end
        offset = seg_addr[PAGE_SHIFT-1:3];
        slot_sum = (PTR_W + 1)'(seg_ptrs) + (PTR_W + 1)'(offset);
        free_slots = SLOTS - SEG_W'(offset);
        seg_chain = slot_sum > (PTR_W + 1)'(SLOTS);
        if (seg_chain)
        begin
            seg_count = free_slots;
            seg_ptr_next = seg_ptrs - PTR_W'(free_slots) + PTR_W'(1);
            seg_data = free_slots - SEG_W'(1);
        end
        else
        begin
            seg_count = SEG_W'(seg_ptrs);
            seg_ptr_next = '0;
            seg_data = SEG_W'(seg_ptrs);
        end
        fetch_item.kind = nvme_prp_pkg::KIND_FETCH;
        fetch_item.to_host_out = 1'b0;
        fetch_item.address = seg_addr;
        fetch_item.byte_length = LEN_W'(seg_count) << 3;
        fetch_item.last = 1'b0;
    end

    // list entry data beat
    always_comb
    begin
        entry_len = (bytes_left_reg > PAGE_BYTES) ? PAGE_BYTES : bytes_left_reg;
        seg_dec = seg_left_reg - SEG_W'(1);
        entry_last = (seg_dec == '0) && !chain_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        dir_next = dir_reg;
        bytes_left_next = bytes_left_reg;
        ptr_left_next = ptr_left_reg;
        seg_left_next = seg_left_reg;
        chain_next = chain_reg;
        push.count = nvme_prp_pkg::PUSH_NONE;
        push.r0 = fetch_item;
        push.r1.kind = nvme_prp_pkg::KIND_DATA;
        push.r1.to_host_out = item_reg.to_host;
        push.r1.address = item_reg.first_pointer;
        push.r1.byte_length = first_len;
        push.r1.last = 1'b0;

        if (item_reg.func == nvme_prp_pkg::FUNC_CMD)
        begin
            dir_next = item_reg.to_host;
            busy_next = 1'b0;
            chain_next = 1'b0;
            seg_left_next = '0;
            ptr_left_next = '0;
            bytes_left_next = '0;
            push.r0.kind = nvme_prp_pkg::KIND_DATA;
            push.r0.to_host_out = item_reg.to_host;
            push.r0.address = item_reg.first_pointer;
            push.r0.last = 1'b0;
            if (pages <= SPAN_W'(1))
            begin
                push.count = nvme_prp_pkg::PUSH_ONE;
                push.r0.byte_length = data_len;
                push.r0.last = 1'b1;
            end
            else if (pages == SPAN_W'(2))
            begin
                push.count = nvme_prp_pkg::PUSH_TWO;
                push.r0.byte_length = first_len;
                push.r1.address = item_reg.second_pointer & PAGE_ADDR_MASK;
                push.r1.byte_length = data_len - first_len;
                push.r1.last = 1'b1;
            end
            else
            begin
                push.count = nvme_prp_pkg::PUSH_TWO;
                push.r0 = fetch_item;
                bytes_left_next = data_len - first_len;
                busy_next = 1'b1;
                ptr_left_next = seg_ptr_next;
                seg_left_next = seg_data;
                chain_next = seg_chain;
            end
        end
        else if (busy_reg)
        begin
            if (seg_left_reg != '0)
            begin
                push.count = nvme_prp_pkg::PUSH_ONE;
                push.r0.kind = nvme_prp_pkg::KIND_DATA;
                push.r0.to_host_out = dir_reg;
                push.r0.address = item_reg.list_entry & PAGE_ADDR_MASK;
                push.r0.byte_length = entry_len;
                push.r0.last = entry_last;
                bytes_left_next = bytes_left_reg - entry_len;
                seg_left_next = seg_dec;
                if (entry_last)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (chain_reg)
            begin
                push.count = nvme_prp_pkg::PUSH_ONE;
                ptr_left_next = seg_ptr_next;
                seg_left_next = seg_data;
                chain_next = seg_chain;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end

        if (!advance)
        begin
            push.count = nvme_prp_pkg::PUSH_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            busy_reg <= 1'b0;
            dir_reg <= 1'b0;
            bytes_left_reg <= '0;
            ptr_left_reg <= '0;
            seg_left_reg <= '0;
            chain_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                busy_reg <= busy_next;
                dir_reg <= dir_next;
                bytes_left_reg <= bytes_left_next;
                ptr_left_reg <= ptr_left_next;
                seg_left_reg <= seg_left_next;
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/nvme_prp_outq.sv */
module nvme_prp_outq
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  nvme_prp_pkg::push_t     push,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output nvme_prp_pkg::out_item_t out_item
);

    localparam int PTR_W = nvme_prp_pkg::OUTQ_PTR_W;
    localparam int CNT_W = nvme_prp_pkg::OUTQ_CNT_W;

    nvme_prp_pkg::out_item_t mem [nvme_prp_pkg::OUTQ_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign room = count_reg <= CNT_W'(nvme_prp_pkg::OUTQ_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item = mem[rd_ptr_reg];
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != nvme_prp_pkg::PUSH_NONE)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.count == nvme_prp_pkg::PUSH_TWO)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

endmodule

/* rtl/nvme_prp_transfer_splitter.sv */
// Splits NVMe commands into page descriptors by walking PRP1, PRP2 and the
// fetched PRP list. One beat is taken per clock while the result queue has
// room: a command or a list entry passes an input register, is resolved
// combinationally against the walk counters and is written into a four-entry
// result queue. Beats that yield one result sustain one per cycle while the
// result port is ready; a command that yields two results (two-page transfer,
// or list fetch plus first page) fills two slots, drained one per cycle when ready.
module nvme_prp_transfer_splitter
#(
    parameter int PAGE_SHIFT = nvme_prp_pkg::PAGE_SHIFT_DEF,
    parameter int BLOCK_BYTES = nvme_prp_pkg::BLOCK_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    nvme_prp_in_if.sink    in_ch,
    nvme_prp_out_if.source out_ch
);

    nvme_prp_pkg::in_item_t  in_item;
    nvme_prp_pkg::out_item_t out_item;
    nvme_prp_pkg::push_t     push;
    logic                    room;

    always_comb
    begin
        in_item.func = in_ch.func;
        in_item.to_host = in_ch.to_host;
        in_item.first_pointer = in_ch.first_pointer;
        in_item.second_pointer = in_ch.second_pointer;
        in_item.block_count_minus_one = in_ch.block_count_minus_one;
        in_item.list_entry = in_ch.list_entry;
    end

    nvme_prp_walk
    #(
        .PAGE_SHIFT  (PAGE_SHIFT),
        .BLOCK_BYTES (BLOCK_BYTES)
    )
    u_walk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_item  (in_item),
        .room     (room),
        .push     (push)
    );

    nvme_prp_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign out_ch.kind = out_item.kind;
    assign out_ch.to_host_out = out_item.to_host_out;
    assign out_ch.address = out_item.address;
    assign out_ch.byte_length = out_item.byte_length;
    assign out_ch.last = out_item.last;

    // results only enter the queue when two slots are free
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != nvme_prp_pkg::PUSH_NONE |-> room)
        else $error("result push without queue room");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == nvme_prp_pkg::PUSH_TWO |-> push.r1.kind == nvme_prp_pkg::KIND_DATA)
        else $error("second result of a beat is not a data descriptor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == nvme_prp_pkg::KIND_FETCH
            |-> !out_ch.to_host_out && !out_ch.last)
        else $error("list fetch marked as card to host or last");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != nvme_prp_pkg::PUSH_NONE && push.count != nvme_prp_pkg::PUSH_ONE
            |-> push.count == nvme_prp_pkg::PUSH_TWO)
        else $error("illegal push count");

endmodule
